FILE: rtl/ising_metropolis_pixel_update_unit_assert.svh
// Assertion macros for the pixel update unit
`ifndef ISING_METROPOLIS_PIXEL_UPDATE_UNIT_ASSERT_SVH
`define ISING_METROPOLIS_PIXEL_UPDATE_UNIT_ASSERT_SVH

// check a property on every clock outside reset
`define IMPU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a consequent in the cycle after its trigger
`define IMPU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/impu_pkg.sv
`timescale 1ns / 1ps
package impu_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int NB_COUNT   = 12;
    localparam int EXP_DEPTH  = 256;
    localparam logic [63:0] EXP_STEP_Q30 = 64'd1008687096;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_COUPLING = 2'd0,
        CFG_WEIGHT   = 2'd1,
        CFG_WIDTH    = 2'd2,
        CFG_HEIGHT   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_DRAIN,
        ST_MUL,
        ST_SUM,
        ST_PROB,
        ST_DONE
    } state_t;

    typedef logic [15:0] exp_table_t [EXP_DEPTH];
    typedef logic signed [2:0] offs_t [NB_COUNT];

    localparam offs_t NB_DR = '{-3'sd1, 3'sd1, 3'sd0, 3'sd0, -3'sd1, 3'sd1,
                                3'sd1, -3'sd1, -3'sd2, 3'sd2, 3'sd0, 3'sd0};
    localparam offs_t NB_DC = '{3'sd0, 3'sd0, -3'sd1, 3'sd1, -3'sd1, -3'sd1,
                                3'sd1, 3'sd1, 3'sd0, 3'sd0, -3'sd2, 3'sd2};

    function automatic exp_table_t build_exp_table();
        exp_table_t  tab;
        logic [63:0] p;
        logic [63:0] v;
        p = 64'd1 << 30;
        for (int k = 0; k < EXP_DEPTH; k++)
        begin
            v = (p + (64'd1 << 13)) >> 14;
            tab[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
            p = (p * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

FILE: rtl/ising_metropolis_pixel_update_unit.sv
`timescale 1ns / 1ps
// Metropolis pixel update unit for binary image denoising.
// Input stream (s_axis): one beat per request. tuser holds the request kind
// (load, update, read); tdata holds address, observation, starting label and
// the uniform random number. Output stream (m_axis): one beat per request
// with label, flip flag, acceptance probability, equal-neighbour count and
// an address error flag. Configuration: cfg_we with cfg_index/cfg_data,
// written only while the unit is idle; the user is bound to this, as the
// block itself does not enforce it. Load, error and unused requests go
// from check to done; a read fetches the center label; an update takes one
// label memory read per cycle for the center and its twelve neighbours,
// then multiply, sum and table lookup. One request is in flight at a time;
// the next beat is taken as soon as the result sits in the output register.
// Reset clears control state and restores the default registers; the image
// memories hold no defined value until loaded. When the receiver stalls the
// result holds in the output register; one more request may complete its
// work and then waits until the register frees.
module ising_metropolis_pixel_update_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row, col, observed, initial_label, uniform (low bit up)
    input  logic [39:0] s_axis_tdata,
    // req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // label, flipped, accept_prob, same_count, addr_error (low bit up)
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import impu_pkg::*;

    `include "ising_metropolis_pixel_update_unit_assert.svh"

    logic              lbl_mem [MAX_WIDTH * MAX_HEIGHT];
    logic [8:0]        obs_mem [MAX_WIDTH * MAX_HEIGHT];

    logic [11:0] coupling_reg;
    logic [15:0] weight_reg;
    logic [6:0]  width_reg;
    logic [6:0]  height_reg;

    state_t      state_reg, state_next;
    req_t        req_reg, req_next;
    logic [5:0]  row_reg, row_next;
    logic [5:0]  col_reg, col_next;
    logic [8:0]  obs_in_reg, obs_in_next;
    logic        init_reg, init_next;
    logic [15:0] uni_reg, uni_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        pend_reg, pend_next;
    logic        pend_ctr_reg, pend_ctr_next;
    logic        pend_inb_reg, pend_inb_next;
    logic        x_reg, x_next;
    logic [8:0]  y_reg, y_next;
    logic [3:0]  nkeep_reg, nkeep_next;
    logic [3:0]  nvalid_reg, nvalid_next;
    logic        flip_reg, flip_next;
    logic        err_reg, err_next;
    logic [15:0] prob_reg, prob_next;
    logic signed [17:0] prod_c_reg, prod_c_next;
    logic signed [27:0] prod_w_reg, prod_w_next;
    logic signed [29:0] delta_reg, delta_next;
    logic        out_valid_reg, out_valid_next;
    logic [22:0] out_data_reg, out_data_next;

    logic              lbl_rd;
    logic [8:0]        obs_rd;
    logic              mem_lbl_we;
    logic              mem_lbl_wd;
    logic              mem_obs_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;

    logic [6:0]  w_use;
    logic [6:0]  h_use;
    logic [ADDR_W-1:0] ctr_addr;
    logic signed [7:0] nb_r;
    logic signed [7:0] nb_c;
    logic        nb_inb;
    logic [3:0]  nb_sel;
    logic [3:0]  last_cnt;
    logic signed [4:0]  n_diff;
    logic signed [10:0] t_val;
    logic [30:0] neg_delta;
    logic [18:0] k_val;
    logic        in_acc;

    assign w_use = (width_reg > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_reg;
    assign h_use = (height_reg > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_reg;
    assign ctr_addr = ADDR_W'(row_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_reg);
    assign nb_sel = (cnt_reg == 4'd0) ? 4'd0 : cnt_reg - 4'd1;
    assign nb_r = $signed({2'b00, row_reg}) + 8'(NB_DR[nb_sel]);
    assign nb_c = $signed({2'b00, col_reg}) + 8'(NB_DC[nb_sel]);
    assign nb_inb = (nb_r >= 0) && (nb_c >= 0) && (nb_r < $signed({1'b0, h_use}))
                    && (nb_c < $signed({1'b0, w_use}));
    assign last_cnt = (req_reg == REQ_READ) ? 4'd0 : 4'(NB_COUNT);
    assign n_diff = $signed({1'b0, nvalid_reg}) - $signed({1'b0, nkeep_reg})
                    - $signed({1'b0, nkeep_reg});
    assign t_val = x_reg ? (11'sd256 - $signed({1'b0, y_reg, 1'b0}))
                         : ($signed({1'b0, y_reg, 1'b0}) - 11'sd256);
    assign neg_delta = 31'(-$signed({delta_reg[29], delta_reg}));
    assign k_val = neg_delta[30:12];
    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

    always_ff @(posedge clk)
    begin
        if (mem_lbl_we)
        begin
            lbl_mem[mem_waddr] <= mem_lbl_wd;
        end
        if (mem_obs_we)
        begin
            obs_mem[mem_waddr] <= obs_in_reg;
        end
        lbl_rd <= lbl_mem[mem_raddr];
        obs_rd <= obs_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupling_reg <= 12'd256;
            weight_reg   <= 16'd128;
            width_reg    <= 7'd64;
            height_reg   <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COUPLING: coupling_reg <= cfg_data[11:0];
                CFG_WEIGHT:   weight_reg   <= cfg_data;
                CFG_WIDTH:    width_reg    <= cfg_data[6:0];
                CFG_HEIGHT:   height_reg   <= cfg_data[6:0];
                default:      coupling_reg <= coupling_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        obs_in_reg   <= obs_in_next;
        init_reg     <= init_next;
        uni_reg      <= uni_next;
        cnt_reg      <= cnt_next;
        pend_ctr_reg <= pend_ctr_next;
        pend_inb_reg <= pend_inb_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        nkeep_reg    <= nkeep_next;
        nvalid_reg   <= nvalid_next;
        flip_reg     <= flip_next;
        err_reg      <= err_next;
        prob_reg     <= prob_next;
        prod_c_reg   <= prod_c_next;
        prod_w_reg   <= prod_w_next;
        delta_reg    <= delta_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        obs_in_next    = obs_in_reg;
        init_next      = init_reg;
        uni_next       = uni_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_ctr_next  = 1'b0;
        pend_inb_next  = 1'b0;
        x_next         = x_reg;
        y_next         = y_reg;
        nkeep_next     = nkeep_reg;
        nvalid_next    = nvalid_reg;
        flip_next      = flip_reg;
        err_next       = err_reg;
        prob_next      = prob_reg;
        prod_c_next    = prod_c_reg;
        prod_w_next    = prod_w_reg;
        delta_next     = delta_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        mem_lbl_we     = 1'b0;
        mem_lbl_wd     = x_reg;
        mem_obs_we     = 1'b0;
        mem_waddr      = ctr_addr;
        mem_raddr      = ctr_addr;

        if (pend_reg)
        begin
            if (pend_ctr_reg)
            begin
                x_next = lbl_rd;
                y_next = obs_rd;
            end
            else if (pend_inb_reg)
            begin
                nvalid_next = nvalid_reg + 4'd1;
                if (lbl_rd == x_reg)
                begin
                    nkeep_next = nkeep_reg + 4'd1;
                end
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    req_next    = req_t'(s_axis_tuser);
                    row_next    = s_axis_tdata[5:0];
                    col_next    = s_axis_tdata[11:6];
                    obs_in_next = s_axis_tdata[20:12];
                    init_next   = s_axis_tdata[21];
                    uni_next    = s_axis_tdata[37:22];
                    cnt_next    = 4'd0;
                    x_next      = 1'b0;
                    nkeep_next  = 4'd0;
                    nvalid_next = 4'd0;
                    flip_next   = 1'b0;
                    err_next    = 1'b0;
                    prob_next   = 16'd0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (req_reg == REQ_NONE)
                begin
                    state_next = ST_DONE;
                end
                else if ({1'b0, row_reg} >= h_use || {1'b0, col_reg} >= w_use)
                begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (req_reg == REQ_LOAD)
                begin
                    mem_lbl_we = 1'b1;
                    mem_lbl_wd = init_reg;
                    mem_obs_we = 1'b1;
                    x_next     = init_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cnt_reg != 4'd0)
                begin
                    mem_raddr = ADDR_W'(nb_r[5:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nb_c[5:0]);
                end
                pend_next     = 1'b1;
                pend_ctr_next = (cnt_reg == 4'd0);
                pend_inb_next = nb_inb;
                cnt_next      = cnt_reg + 4'd1;
                if (cnt_reg == last_cnt)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = (req_reg == REQ_READ) ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                prod_c_next = $signed({1'b0, coupling_reg}) * n_diff;
                prod_w_next = $signed({1'b0, weight_reg}) * t_val;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                delta_next = 30'($signed({prod_c_reg, 8'd0})) + 30'(prod_w_reg);
                state_next = ST_PROB;
            end
            ST_PROB:
            begin
                if (!delta_reg[29])
                begin
                    prob_next = 16'hFFFF;
                end
                else if (k_val >= 19'(EXP_DEPTH))
                begin
                    prob_next = 16'd0;
                end
                else
                begin
                    prob_next = EXP_TABLE[k_val[7:0]];
                end
                if (uni_reg < prob_next)
                begin
                    flip_next  = 1'b1;
                    x_next     = !x_reg;
                    mem_lbl_we = 1'b1;
                    mem_lbl_wd = !x_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {err_reg, nkeep_reg, prob_reg, flip_reg, x_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `IMPU_ASSERT(a_err_clean, m_axis_tvalid && m_axis_tdata[22] |-> m_axis_tdata[21:0] == 22'd0,
        "address error result carries data")
    `IMPU_ASSERT(a_flip_prob, m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[17:2] != 16'd0,
        "flip with zero probability")
    `IMPU_ASSERT(a_count_max, m_axis_tvalid |-> m_axis_tdata[21:18] <= 4'(NB_COUNT),
        "equal-neighbour count above twelve")
    `IMPU_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "second beat taken while busy")
    `IMPU_ASSERT(a_write_once, mem_lbl_we |-> state_reg == ST_CHECK || state_reg == ST_PROB,
        "label write outside load or update")

endmodule

FILE: test/ising_metropolis_pixel_update_unit_tb.sv
`timescale 1ns / 1ps
module ising_metropolis_pixel_update_unit_tb;
    import impu_pkg::*;

    typedef struct packed {
        logic        addr_error;
        logic [3:0]  same_count;
        logic [15:0] accept_prob;
        logic        flipped;
        logic        label;
    } pixel_result_t;

    typedef struct {
        req_t        kind;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [8:0]  observed;
        logic        init_label;
        logic [15:0] uniform;
        logic        typed;
        logic        exp_label;
        logic        exp_err;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    ising_metropolis_pixel_update_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    logic          label_img [MAX_WIDTH*MAX_HEIGHT];
    logic [8:0]    obs_img [MAX_WIDTH*MAX_HEIGHT];
    logic [11:0]   beta;
    logic [15:0]   lweight;
    logic [6:0]    img_w;
    logic [6:0]    img_h;
    pixel_result_t pending_results [$];
    stim_row_t     pending_rows [$];
    int            fail_count;
    int            hold_off;
    bit            stall_en;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int eff_w();
        return (img_w > MAX_WIDTH) ? MAX_WIDTH : int'(img_w);
    endfunction

    function automatic int eff_h();
        return (img_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(img_h);
    endfunction

    function automatic logic [15:0] exp_lookup(int k);
        longint unsigned p;
        longint unsigned v;
        p = 64'd1 << 30;
        for (int i = 0; i < k; i++)
            p = (p * 64'd1008687096 + (64'd1 << 29)) >> 30;
        v = (p + (64'd1 << 13)) >> 14;
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic pixel_result_t metropolis_step(stim_row_t s);
        pixel_result_t res;
        int            r;
        int            c;
        int            idx;
        int            n_keep;
        int            n_valid;
        logic          x;
        longint        y;
        longint        t;
        longint        delta;
        longint        k;
        logic [15:0]   prob;
        int            dr [12] = '{-1, 1, 0, 0, -1, 1, 1, -1, -2, 2, 0, 0};
        int            dc [12] = '{0, 0, -1, 1, -1, -1, 1, 1, 0, 0, -2, 2};
        res = '0;
        if (s.kind == REQ_NONE)
            return res;
        if (int'(s.row) >= eff_h() || int'(s.col) >= eff_w())
        begin
            res.addr_error = 1'b1;
            return res;
        end
        idx = s.row * MAX_WIDTH + s.col;
        if (s.kind == REQ_LOAD)
        begin
            label_img[idx] = s.init_label;
            obs_img[idx] = s.observed;
            res.label = s.init_label;
            return res;
        end
        if (s.kind == REQ_READ)
        begin
            res.label = label_img[idx];
            return res;
        end
        x = label_img[idx];
        y = obs_img[idx];
        n_keep = 0;
        n_valid = 0;
        for (int n = 0; n < 12; n++)
        begin
            r = s.row + dr[n];
            c = s.col + dc[n];
            if (r < 0 || c < 0 || r >= eff_h() || c >= eff_w())
                continue;
            n_valid++;
            if (label_img[r * MAX_WIDTH + c] == x)
                n_keep++;
        end
        t = (x == 1'b0) ? (2 * y - 256) : (256 - 2 * y);
        delta = longint'(beta) * (n_valid - 2 * n_keep) * 256 + longint'(lweight) * t;
        if (delta >= 0)
            prob = 16'hFFFF;
        else
        begin
            k = (-delta) >>> 12;
            prob = (k >= 256) ? 16'd0 : exp_lookup(int'(k));
        end
        if (s.uniform < prob)
        begin
            x = ~x;
            label_img[idx] = x;
            res.flipped = 1'b1;
        end
        res.label = x;
        res.accept_prob = prob;
        res.same_count = n_keep[3:0];
        return res;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_COUPLING: beta = val[11:0];
            CFG_WEIGHT:   lweight = val;
            CFG_WIDTH:    img_w = val[6:0];
            CFG_HEIGHT:   img_h = val[6:0];
            default: ;
        endcase
    endtask

    task automatic send_beat(stim_row_t s);
        pixel_result_t res;
        s_axis_tdata = {s.uniform, s.init_label, s.observed, s.col, s.row};
        s_axis_tuser = s.kind;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = metropolis_step(s);
        if (s.typed && (res.label != s.exp_label || res.addr_error != s.exp_err))
        begin
            $error("table row label/addr_error: expected %0d/%0d actual %0d/%0d",
                   s.exp_label, s.exp_err, res.label, res.addr_error);
            fail_count++;
        end
        pending_results.push_back(res);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_burst(stim_row_t rows [$]);
        int gap;
        foreach (rows[i])
        begin
            send_beat(rows[i]);
            if ($urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 8);
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (30) @(negedge clk);
    endtask

    function automatic stim_row_t mk(req_t kind, int r, int c, int obs, int lab, int uni);
        stim_row_t s;
        s.kind = kind;
        s.row = r[5:0];
        s.col = c[5:0];
        s.observed = obs[8:0];
        s.init_label = lab[0];
        s.uniform = uni[15:0];
        s.typed = 1'b0;
        s.exp_label = 1'b0;
        s.exp_err = 1'b0;
        return s;
    endfunction

    function automatic stim_row_t mkt(req_t kind, int r, int c, int obs, int lab,
                                      int uni, int el, int ee);
        stim_row_t s;
        s = mk(kind, r, c, obs, lab, uni);
        s.typed = 1'b1;
        s.exp_label = el[0];
        s.exp_err = ee[0];
        return s;
    endfunction

    function automatic stim_row_t rand_row(int w, int h, int pct_update);
        stim_row_t s;
        int        sel;
        int        r;
        int        c;
        sel = $urandom_range(0, 99);
        s = mk(REQ_LOAD, 0, 0, $urandom_range(0, 511), $urandom_range(0, 1), $urandom);
        r = $urandom_range(0, h - 1);
        c = $urandom_range(0, w - 1);
        if (sel < pct_update)
            s.kind = REQ_UPDATE;
        else if (sel < pct_update + 15)
            s.kind = REQ_READ;
        else if (sel < pct_update + 20)
            s.kind = REQ_NONE;
        else if (sel < pct_update + 26)
        begin
            s.kind = req_t'($urandom_range(0, 2));
            r = $urandom_range(0, 63);
            c = $urandom_range(0, 63);
            if (r < h && c < w)
                s.kind = REQ_READ;
        end
        s.row = r[5:0];
        s.col = c[5:0];
        if (s.kind == REQ_UPDATE && $urandom_range(0, 3) == 0)
            s.uniform = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return s;
    endfunction

    task automatic fill_image(int w, int h);
        stim_row_t rows [$];
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                rows.push_back(mk(REQ_LOAD, r, c, $urandom_range(0, 256),
                                  $urandom_range(0, 1), $urandom));
        send_burst(rows);
    endtask

    task automatic random_phase(int w, int h, int count);
        stim_row_t rows [$];
        for (int i = 0; i < count; i++)
            rows.push_back(rand_row(w, h, 55));
        send_burst(rows);
    endtask

    always @(posedge clk)
    begin
        pixel_result_t got;
        pixel_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[22:0];
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.label != want.label)
                begin
                    $error("label expected %0d actual %0d", want.label, got.label);
                    fail_count++;
                end
                if (got.flipped != want.flipped)
                begin
                    $error("flipped expected %0d actual %0d", want.flipped, got.flipped);
                    fail_count++;
                end
                if (got.accept_prob != want.accept_prob)
                begin
                    $error("accept_prob expected %0d actual %0d",
                           want.accept_prob, got.accept_prob);
                    fail_count++;
                end
                if (got.same_count != want.same_count)
                begin
                    $error("same_count expected %0d actual %0d",
                           want.same_count, got.same_count);
                    fail_count++;
                end
                if (got.addr_error != want.addr_error)
                begin
                    $error("addr_error expected %0d actual %0d",
                           want.addr_error, got.addr_error);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (stall_en)
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        stim_row_t rows [$];
        int        wsel;
        int        hsel;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_NONE;
        cfg_we = 1'b0;
        cfg_index = CFG_COUPLING;
        cfg_data = '0;
        hold_off = 0;
        stall_en = 1'b0;
        fail_count = 0;
        beta = 12'd256;
        lweight = 16'd128;
        img_w = 7'd64;
        img_h = 7'd64;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_WIDTH, 16'd4);
        write_reg(CFG_HEIGHT, 16'd4);
        fill_image(4, 4);
        rows = {};
        rows.push_back(mkt(REQ_LOAD, 0, 0, 256, 1, 0, 1, 0));
        rows.push_back(mkt(REQ_LOAD, 3, 3, 0, 0, 65535, 0, 0));
        rows.push_back(mkt(REQ_LOAD, 1, 2, 511, 1, 0, 1, 0));
        rows.push_back(mkt(REQ_READ, 0, 0, 0, 0, 0, 1, 0));
        rows.push_back(mkt(REQ_READ, 3, 3, 0, 0, 0, 0, 0));
        rows.push_back(mkt(REQ_LOAD, 4, 0, 7, 1, 0, 0, 1));
        rows.push_back(mkt(REQ_UPDATE, 0, 63, 0, 0, 0, 0, 1));
        rows.push_back(mkt(REQ_READ, 63, 63, 0, 0, 0, 0, 1));
        rows.push_back(mkt(REQ_NONE, 1, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_UPDATE, 0, 0, 0, 0, 0));
        rows.push_back(mk(REQ_UPDATE, 3, 3, 0, 0, 65535));
        rows.push_back(mk(REQ_UPDATE, 1, 2, 0, 0, 32768));
        rows.push_back(mk(REQ_UPDATE, 1, 1, 0, 0, 0));
        rows.push_back(mk(REQ_UPDATE, 2, 2, 0, 0, 1));
        send_burst(rows);
        drain();

        stall_en = 1'b1;
        write_reg(CFG_COUPLING, 16'hFFF);
        write_reg(CFG_WEIGHT, 16'hFFFF);
        random_phase(4, 4, 60);
        drain();
        write_reg(CFG_COUPLING, 16'd0);
        write_reg(CFG_WEIGHT, 16'd0);
        random_phase(4, 4, 30);
        drain();

        write_reg(CFG_WIDTH, 16'd1);
        write_reg(CFG_HEIGHT, 16'd1);
        write_reg(CFG_COUPLING, 16'd300);
        write_reg(CFG_WEIGHT, 16'd900);
        fill_image(1, 1);
        random_phase(1, 1, 30);
        drain();

        write_reg(CFG_WIDTH, 16'd0);
        rows = {};
        rows.push_back(mkt(REQ_READ, 0, 0, 0, 0, 0, 0, 1));
        rows.push_back(mkt(REQ_LOAD, 0, 0, 3, 1, 0, 0, 1));
        send_burst(rows);
        drain();
        write_reg(CFG_WIDTH, 16'h7F);
        write_reg(CFG_HEIGHT, 16'd3);
        fill_image(64, 3);
        random_phase(64, 3, 80);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            wsel = $urandom_range(2, 9);
            hsel = $urandom_range(2, 9);
            write_reg(CFG_WIDTH, wsel[15:0]);
            write_reg(CFG_HEIGHT, hsel[15:0]);
            write_reg(CFG_COUPLING, 16'($urandom_range(0, 1023)));
            write_reg(CFG_WEIGHT, 16'($urandom_range(0, 2047)));
            stall_en = ph[0];
            fill_image(wsel, hsel);
            if (ph == 2)
                hold_off = 400;
            random_phase(wsel, hsel, 80);
            drain();
        end

        write_reg(CFG_WIDTH, 16'd64);
        write_reg(CFG_HEIGHT, 16'd64);
        write_reg(CFG_COUPLING, 16'd256);
        write_reg(CFG_WEIGHT, 16'd128);
        rows = {};
        rows.push_back(mk(REQ_LOAD, 63, 63, 256, 0, 0));
        rows.push_back(mk(REQ_LOAD, 62, 63, 0, 1, 0));
        rows.push_back(mk(REQ_LOAD, 61, 63, 0, 1, 0));
        rows.push_back(mk(REQ_LOAD, 63, 62, 0, 1, 0));
        rows.push_back(mk(REQ_LOAD, 63, 61, 0, 1, 0));
        rows.push_back(mk(REQ_LOAD, 62, 62, 0, 0, 0));
        rows.push_back(mk(REQ_UPDATE, 63, 63, 0, 0, 100));
        rows.push_back(mk(REQ_READ, 63, 63, 0, 0, 0));
        send_burst(rows);
        drain();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
